// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the rejection exponent block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, ck, rn, cond, msg)
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== src/gre_pkg.sv =====
// Package of constants for the Gaussian rejection exponent block.
package gre_pkg;
    localparam int unsigned W = 64;
    localparam int unsigned CNT_W = $clog2(W);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] CFG_SIGMA_NUM = 2'd0;
    localparam logic [1:0] CFG_SIGMA_DEN = 2'd1;
    localparam logic [1:0] CFG_TRY_LIMIT = 2'd2;
endpackage

// ===== src/gaussian_rejection_exponent.sv =====
// Top level of the Gaussian rejection exponent block: sequencer and shared datapath.
//
// channel   | dir | handshake                   | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata: candidate; tuser: shift_bit
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: exp_num, exp_den; tuser: status
// cfg       | in  | cfg_we                      | cfg_addr, cfg_wdata
//
// An item passes through an accept step, five 64-step shift-add multiplies
// (n2, m2, d*m2, v*v, n2*m2), a binary gcd, two 64-step restoring divisions
// and a finish step, all sequenced over one shared 64-bit datapath. An
// invalid configuration, an overflow or a zero numerator finishes early.
// Reset clears the control state and loads the configuration registers with 1.
// A finished result waits in the output register; the next item is taken
// meanwhile, and the sequencer holds at its last step only while that
// register is still full.
`include "assert_macros.svh"
module gaussian_rejection_exponent
    import gre_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] candidate
    input  logic         s_axis_tuser,   // [0] shift_bit
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [63:0] exp_num, [127:64] exp_den
    output logic [1:0]   m_axis_tuser,   // [1:0] status
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_GTWO, S_GLOOP, S_DIV, S_FIN} state_t;
    typedef enum logic [2:0] {M_N2, M_M2, M_A, M_NUM, M_DEN0} mop_t;

    state_t state_reg;
    mop_t   mop_reg;

    logic [31:0] sigma_num_reg, sigma_den_reg;
    logic [15:0] try_limit_reg;

    logic [32:0]    d_reg;
    logic [W-1:0]   n2_reg, m2_reg;
    logic [W-1:0]   ma_reg, mb_reg, acc_reg;
    logic           ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]   num_reg, den_reg;
    logic [W-1:0]   ga_reg, gb_reg;
    logic [W-1:0]   dq_reg, rem_reg;
    logic           div_sel_reg;
    logic [1:0]     res_st_reg;

    logic           out_valid_reg;
    logic [W-1:0]   out_num_reg, out_den_reg;
    logic [1:0]     out_st_reg;

    // Input decode: d = |2*candidate - shift_bit|.
    logic signed [33:0] q_s;
    logic [32:0]        d_next;
    logic               cfg_bad;

    // Shared multiply step (MSB first) and divide step.
    logic [W:0]   mul_sum;
    logic         mul_ovf_next;
    logic [W-1:0] acc_next;
    logic [W:0]   rem_sh;
    logic         div_ge;
    logic [W-1:0] rem_next, dq_next;
    logic [W-1:0] v_next;

    always_comb
    begin
        q_s     = $signed({s_axis_tdata[31], s_axis_tdata, 1'b0}) - $signed({33'd0, s_axis_tuser});
        d_next  = q_s[33] ? 33'(-q_s) : q_s[32:0];
        cfg_bad = (sigma_num_reg == '0) || (sigma_den_reg == '0) || (try_limit_reg == '0);

        mul_sum      = {1'b0, acc_reg[W-2:0], 1'b0} + {1'b0, (mb_reg[W-1] ? ma_reg : '0)};
        mul_ovf_next = ovf_reg | acc_reg[W-1] | mul_sum[W];
        acc_next     = mul_sum[W-1:0];

        rem_sh   = {rem_reg, dq_reg[W-1]};
        div_ge   = rem_sh >= {1'b0, ga_reg};
        rem_next = div_ge ? W'(rem_sh - {1'b0, ga_reg}) : rem_sh[W-1:0];
        dq_next  = {dq_reg[W-2:0], div_ge};

        v_next = (acc_next > n2_reg) ? (acc_next - n2_reg) : (n2_reg - acc_next);
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_den_reg, out_num_reg};
    assign m_axis_tuser  = out_st_reg;

    // Configuration registers; writes beyond the list drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_num_reg <= 32'd1;
            sigma_den_reg <= 32'd1;
            try_limit_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SIGMA_NUM: sigma_num_reg <= cfg_wdata;
                CFG_SIGMA_DEN: sigma_den_reg <= cfg_wdata;
                CFG_TRY_LIMIT: try_limit_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    d_reg   <= d_next;
                    ma_reg  <= {32'd0, sigma_num_reg};
                    mb_reg  <= {32'd0, sigma_num_reg};
                    acc_reg <= '0;
                    ovf_reg <= 1'b0;
                    cnt_reg <= '0;
                    num_reg <= '0;
                    den_reg <= '0;
                    res_st_reg <= cfg_bad ? ST_INVALID : ST_OK;
                end
            end
            S_MUL:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    // Launch the next product from the one just finished.
                    acc_reg <= '0;
                    ovf_reg <= 1'b0;
                    case (mop_reg)
                        M_N2:
                        begin
                            n2_reg <= acc_next;
                            ma_reg <= {32'd0, sigma_den_reg};
                            mb_reg <= {32'd0, sigma_den_reg};
                        end
                        M_M2:
                        begin
                            m2_reg <= acc_next;
                            ma_reg <= {31'd0, d_reg};
                            mb_reg <= acc_next;
                        end
                        M_A:
                        begin
                            ma_reg <= v_next;
                            mb_reg <= v_next;
                            if (mul_ovf_next)
                                res_st_reg <= ST_OVERFLOW;
                        end
                        M_NUM:
                        begin
                            num_reg <= acc_next;
                            ma_reg  <= n2_reg;
                            mb_reg  <= m2_reg;
                            if (mul_ovf_next)
                                res_st_reg <= ST_OVERFLOW;
                        end
                        default:
                        begin
                            // A zero numerator reduces to 0 / 1 directly.
                            den_reg <= (num_reg == '0) ? W'(1) : {acc_next[W-3:0], 2'b00};
                            ga_reg  <= num_reg;
                            gb_reg  <= {acc_next[W-3:0], 2'b00};
                            if (mul_ovf_next || (acc_next[W-1:W-2] != 2'b00))
                                res_st_reg <= ST_OVERFLOW;
                        end
                    endcase
                end
                else
                begin
                    acc_reg <= acc_next;
                    ovf_reg <= mul_ovf_next;
                    mb_reg  <= {mb_reg[W-2:0], 1'b0};
                end
            end
            S_GTWO:
            begin
                // Strip common factors of two from both operands and results.
                if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_reg  <= ga_reg >> 1;
                    gb_reg  <= gb_reg >> 1;
                    num_reg <= num_reg >> 1;
                    den_reg <= den_reg >> 1;
                end
            end
            S_GLOOP:
            begin
                if (ga_reg == gb_reg)
                begin
                    dq_reg  <= num_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    div_sel_reg <= 1'b0;
                end
                else if (!ga_reg[0])
                    ga_reg <= ga_reg >> 1;
                else if (!gb_reg[0])
                    gb_reg <= gb_reg >> 1;
                else if (ga_reg > gb_reg)
                    ga_reg <= ga_reg - gb_reg;
                else
                    gb_reg <= gb_reg - ga_reg;
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1) && !div_sel_reg)
                begin
                    num_reg <= dq_next;
                    dq_reg  <= den_reg;
                    rem_reg <= '0;
                    div_sel_reg <= 1'b1;
                end
                else
                begin
                    dq_reg  <= dq_next;
                    rem_reg <= rem_next;
                    if (cnt_reg == CNT_W'(W - 1))
                        den_reg <= dq_next;
                end
            end
            default: ;
        endcase

        if (state_reg == S_FIN && (!out_valid_reg || m_axis_tready))
        begin
            out_st_reg  <= res_st_reg;
            out_num_reg <= (res_st_reg == ST_OK) ? num_reg : '0;
            out_den_reg <= (res_st_reg == ST_OK) ? den_reg : '0;
        end
    end

    // Sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mop_reg       <= M_N2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FIN && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        mop_reg   <= M_N2;
                        state_reg <= cfg_bad ? S_FIN : S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (cnt_reg == CNT_W'(W - 1))
                    begin
                        unique case (mop_reg)
                            M_N2: mop_reg <= M_M2;
                            M_M2: mop_reg <= M_A;
                            M_A:
                            begin
                                mop_reg <= M_NUM;
                                if (mul_ovf_next)
                                    state_reg <= S_FIN;
                            end
                            M_NUM:
                            begin
                                mop_reg <= M_DEN0;
                                if (mul_ovf_next)
                                    state_reg <= S_FIN;
                            end
                            M_DEN0:
                            begin
                                // A zero numerator reduces to 0 / 1 with gcd = den.
                                if (mul_ovf_next || (acc_next[W-1:W-2] != 2'b00)
                                    || (num_reg == '0))
                                    state_reg <= S_FIN;
                                else
                                    state_reg <= S_GTWO;
                            end
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                S_GTWO:
                begin
                    if (ga_reg[0] || gb_reg[0])
                        state_reg <= S_GLOOP;
                end
                S_GLOOP:
                begin
                    if (ga_reg == gb_reg)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == CNT_W'(W - 1) && div_sel_reg)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_status_code, clk, rst_n, !m_axis_tvalid || (m_axis_tuser != 2'd3), "bad status code")
    `ASSERT_IMPLY(a_zero_on_error, clk, rst_n, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "nonzero data with error status")
    `ASSERT_IMPLY(a_den_nonzero, clk, rst_n, m_axis_tvalid && (m_axis_tuser == ST_OK), m_axis_tdata[127:64] != '0, "zero denominator with ok status")

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the Gaussian rejection exponent block: random and directed items, self-checking.
`timescale 1ns / 1ps
module tb_top;
    import gre_pkg::*;

    typedef struct packed {
        logic [31:0] candidate;
        logic        shift_bit;
    } sample_t;

    typedef struct packed {
        logic [63:0] exp_num;
        logic [63:0] exp_den;
        logic [1:0]  status;
    } exponent_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // [31:0] candidate
    logic         s_axis_tuser;   // [0] shift_bit
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // [63:0] exp_num, [127:64] exp_den
    logic [1:0]   m_axis_tuser;   // [1:0] status
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [31:0]  cfg_wdata;

    gaussian_rejection_exponent u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Predictor's copy of the configuration registers.
    logic [31:0] sig_num;
    logic [31:0] sig_den;
    logic [15:0] tries;

    sample_t     pending_q[$];   // items waiting for the driver
    exponent_t   exponent_q[$];  // predicted results, oldest first
    int          errors = 0;
    int          cycle_cnt = 0;
    int          hold_cycles = 0; // receiver hold-off, counted by its own process
    bit          hold_req = 0;    // start one long hold-off
    bit          hold_done = 0;
    int          send_gap;
    int          recv_gap;
    bit          send_done;

    // Product of two 64-bit values; flag set when it does not fit in 64 bits.
    function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] b,
                                          inout bit ovf);
        logic [127:0] p;
        p = a * b;
        if (p[127:64] != 0)
            ovf = 1;
        return p[63:0];
    endfunction

    function automatic logic [63:0] euclid(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Exact rejection exponent for one sample under the current settings.
    function automatic exponent_t rejection_exponent(input sample_t s);
        exponent_t   e;
        longint      q;
        logic [63:0] d, n2, m2, a, v, num, den, g;
        bit          ovf;
        e = '0;
        ovf = 0;
        if (sig_num == 0 || sig_den == 0 || tries == 0)
        begin
            e.status = ST_INVALID;
            return e;
        end
        q = 2 * longint'($signed(s.candidate)) - longint'(s.shift_bit);
        d = (q < 0) ? -q : q;
        n2 = {32'd0, sig_num} * {32'd0, sig_num};
        m2 = {32'd0, sig_den} * {32'd0, sig_den};
        a = mul64(d, m2, ovf);
        if (!ovf)
        begin
            v = (a > n2) ? a - n2 : n2 - a;
            num = mul64(v, v, ovf);
            den = mul64(mul64(n2, m2, ovf), 64'd4, ovf);
        end
        if (ovf)
        begin
            e.status = ST_OVERFLOW;
            return e;
        end
        g = euclid(num, den);
        if (g != 0)
        begin
            num = num / g;
            den = den / g;
        end
        e.exp_num = num;
        e.exp_den = den;
        e.status  = ST_OK;
        return e;
    endfunction

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: present queued items, predict each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                exponent_q.push_back(rejection_exponent({s_axis_tdata, s_axis_tuser}));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0 || pending_q.size() == 0)
                begin
                    s_axis_tvalid <= 0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end
                else
                begin
                    sample_t s;
                    s = pending_q.pop_front();
                    s_axis_tvalid <= 1;
                    s_axis_tdata  <= s.candidate;
                    s_axis_tuser  <= s.shift_bit;
                    send_gap      <= pick_gap();
                end
            end
        end
    end

    // Long receiver hold-off, started once on request and counted down here.
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_cycles <= 3000;
            hold_done   <= 1;
        end
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 0;
            recv_gap      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                exponent_t got, want;
                got = {m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser};
                if (exponent_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result num=%h den=%h status=%0d", $time,
                             got.exp_num, got.exp_den, got.status);
                end
                else
                begin
                    want = exponent_q.pop_front();
                    if (got.exp_num !== want.exp_num)
                    begin
                        errors++;
                        $display("%0t: exp_num expected %h actual %h", $time,
                                 want.exp_num, got.exp_num);
                    end
                    if (got.exp_den !== want.exp_den)
                    begin
                        errors++;
                        $display("%0t: exp_den expected %h actual %h", $time,
                                 want.exp_den, got.exp_den);
                    end
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                    end
                end
            end
            // A long hold-off takes priority over the random stalls.
            if (hold_cycles > 0)
                m_axis_tready <= 0;
            else if (recv_gap > 0)
            begin
                m_axis_tready <= 0;
                recv_gap      <= recv_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1;
                recv_gap      <= pick_gap();
            end
        end
    end

    // Cycle counter with a generous limit.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > 4000000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_item(input logic [31:0] c, input logic t);
        sample_t s;
        s.candidate = c;
        s.shift_bit = t;
        pending_q.push_back(s);
    endtask

    // Drain the block, leave a margin, then a register may be written.
    task automatic drain();
        while (pending_q.size() != 0 || s_axis_tvalid || exponent_q.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 0;
        case (idx)
            CFG_SIGMA_NUM: sig_num = val;
            CFG_SIGMA_DEN: sig_den = val;
            CFG_TRY_LIMIT: tries   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_sigma(input logic [31:0] n, input logic [31:0] d, input logic [15:0] l);
        drain();
        write_reg(CFG_SIGMA_NUM, n);
        write_reg(CFG_SIGMA_DEN, d);
        write_reg(CFG_TRY_LIMIT, {16'd0, l});
    endtask

    // Random candidate: mostly small magnitudes, some full range.
    function automatic logic [31:0] rand_candidate();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(0, 400) - 200;
        if (r < 8) return $urandom_range(0, 2000000) - 1000000;
        return $urandom;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            add_item(rand_candidate(), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        sig_num = 1;
        sig_den = 1;
        tries = 1;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // Directed: field extremes under reset settings, zero numerator, both cosets.
        add_item(32'h0000_0000, 0);
        add_item(32'h0000_0000, 1);
        add_item(32'h0000_0001, 1);
        add_item(32'h0000_0001, 0);
        add_item(32'hFFFF_FFFF, 1);
        add_item(32'h7FFF_FFFF, 0);
        add_item(32'h8000_0000, 1);
        add_item(32'h8000_0000, 0);
        add_item(32'h5555_5555, 1);
        add_item(32'hAAAA_AAAA, 0);
        // Large sigma: d*m2 and v*v overflow on big candidates.
        set_sigma(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_item(32'h0000_0000, 0);
        add_item(32'h0000_0001, 1);
        add_item(32'h7FFF_FFFF, 1);
        // Settings with n2*m2 and x4 too large; these items overflow at v*v first.
        set_sigma(32'hFFFF_FFFF, 32'h0000_0002, 16'd3);
        add_item(32'h0000_0000, 0);
        set_sigma(32'h8000_0000, 32'h0000_0001, 16'd1);
        add_item(32'h0000_0002, 1);
        // Invalid settings, one register at a time.
        set_sigma(32'd0, 32'd3, 16'd5);
        add_item(32'h0000_0007, 1);
        set_sigma(32'd3, 32'd0, 16'd5);
        add_item(32'hFFFF_FFF0, 0);
        set_sigma(32'd3, 32'd2, 16'd0);
        add_item(32'h0000_0010, 1);

        // Random phases over several settings.
        set_sigma(32'd5, 32'd2, 16'd9);
        random_phase(150);
        // Pause until every result is back.
        drain();
        set_sigma($urandom_range(1, 1000), $urandom_range(1, 100),
                  16'($urandom_range(1, 65535)));
        // Long receiver hold-off while the sender keeps offering.
        hold_req = 1;
        random_phase(150);
        set_sigma($urandom, $urandom_range(1, 65535), 16'hFFFF);
        random_phase(120);
        set_sigma($urandom_range(1, 65535), $urandom, 16'($urandom_range(1, 65535)));
        random_phase(120);
        set_sigma(32'd1, 32'd1, 16'd1);
        random_phase(150);

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
